/* sv/rng_pkg.sv */
`default_nettype none

package rng_pkg;

    // Status of the shared divider as seen by the sequencer.
    typedef struct packed {
        logic busy;
        logic done;
    } rng_div_status_t;

endpackage

`default_nettype wire

/* sv/rng_div.sv */
`default_nettype none

module rng_div #(
    parameter int DATA_WIDTH = 32
) (
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  wire logic                        start,
    input  wire logic [DATA_WIDTH-1:0]       dividend,
    input  wire logic [DATA_WIDTH-1:0]       divisor,
    output rng_pkg::rng_div_status_t         status,
    output logic      [DATA_WIDTH-1:0]       quotient,
    output logic      [DATA_WIDTH-1:0]       remainder
);

    import rng_pkg::*;

    localparam int CNT_W = (DATA_WIDTH > 1) ? $clog2(DATA_WIDTH) : 1;
    localparam logic [CNT_W-1:0] LAST_STEP = CNT_W'(DATA_WIDTH - 1);

    logic                  busy_reg;
    logic                  busy_next;
    logic                  done_reg;
    logic                  done_next;
    logic [CNT_W-1:0]      cnt_reg;
    logic [CNT_W-1:0]      cnt_next;
    logic [DATA_WIDTH-1:0] rem_reg;
    logic [DATA_WIDTH-1:0] rem_next;
    logic [DATA_WIDTH-1:0] quot_reg;
    logic [DATA_WIDTH-1:0] quot_next;
    logic [DATA_WIDTH-1:0] dvs_reg;
    logic [DATA_WIDTH-1:0] dvs_next;
    logic [DATA_WIDTH:0]   partial;
    logic [DATA_WIDTH:0]   trial;

    // One restoring step per cycle: shift in the next dividend bit and try a subtract.
    always_comb
    begin
        partial   = {rem_reg, quot_reg[DATA_WIDTH-1]};
        trial     = partial - {1'b0, dvs_reg};
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        rem_next  = rem_reg;
        quot_next = quot_reg;
        dvs_next  = dvs_reg;
        if (start)
        begin
            busy_next = 1'b1;
            cnt_next  = LAST_STEP;
            rem_next  = '0;
            quot_next = dividend;
            dvs_next  = divisor;
        end
        else if (busy_reg)
        begin
            if (trial[DATA_WIDTH])
            begin
                rem_next  = partial[DATA_WIDTH-1:0];
                quot_next = {quot_reg[DATA_WIDTH-2:0], 1'b0};
            end
            else
            begin
                rem_next  = trial[DATA_WIDTH-1:0];
                quot_next = {quot_reg[DATA_WIDTH-2:0], 1'b1};
            end
            cnt_next = cnt_reg - 1'b1;
            if (cnt_reg == '0)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    // Control state is reset; the datapath registers are loaded on start.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg  <= rem_next;
        quot_reg <= quot_next;
        dvs_reg  <= dvs_next;
    end

    assign status.busy = busy_reg;
    assign status.done = done_reg;
    assign quotient    = quot_reg;
    assign remainder   = rem_reg;

endmodule

`default_nettype wire

/* sv/rational_normalize_gcd_top.sv */
// Rational normalizer: reduces a signed fraction numerator_in/denominator_in to
// lowest terms, with the sign on the numerator and a nonnegative denominator.
// A zero numerator gives 0/1; a zero denominator gives +1/0 or -1/0.
// Input channel: in_valid/in_stall with numerator_in and denominator_in. A beat
// is taken when in_valid is high and in_stall is low. in_stall is low only while
// the sequencer is idle, so one fraction is worked on at a time.
// Output channel: out_valid/out_stall with reduced_numerator and
// reduced_denominator, held in an output register until the beat is taken.
// Sequence from the accepting edge to the load of the output register: a zero
// numerator goes straight to ST_FINISH. Otherwise every division runs on one
// shared restoring divider at one quotient bit per cycle: ST_GCD_NEXT and
// ST_GCD_WAIT for each Euclid remainder step (at most about 1.44 * DATA_WIDTH
// of them), ST_RN_START through ST_RD_WAIT for the divisions by the gcd, then
// ST_FINISH, which loads the output register; the next beat is taken in ST_IDLE.
// A new fraction is accepted while the previous result still waits in the
// output register; a finished result waits in its final state while the
// receiver stalls and the register is full.
// Reset clears the sequencer and the output valid; no result is pending after it.
`default_nettype none

module rational_normalize_gcd_top #(
    parameter int DATA_WIDTH = 32
) (
    input  wire logic                         clk,
    input  wire logic                         rst_n,
    input  wire logic                         in_valid,
    output logic                              in_stall,
    input  wire logic signed [DATA_WIDTH-1:0] numerator_in,
    input  wire logic signed [DATA_WIDTH-1:0] denominator_in,
    output logic                              out_valid,
    input  wire logic                         out_stall,
    output logic signed      [DATA_WIDTH-1:0] reduced_numerator,
    output logic             [DATA_WIDTH-2:0] reduced_denominator
);

    import rng_pkg::*;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_GCD_NEXT,
        ST_GCD_WAIT,
        ST_RN_START,
        ST_RN_WAIT,
        ST_RD_START,
        ST_RD_WAIT,
        ST_FINISH
    } state_t;

    state_t                state_reg;
    state_t                state_next;
    logic                  neg_reg;
    logic                  neg_next;
    logic [DATA_WIDTH-1:0] n_mag_reg;
    logic [DATA_WIDTH-1:0] n_mag_next;
    logic [DATA_WIDTH-1:0] d_mag_reg;
    logic [DATA_WIDTH-1:0] d_mag_next;
    logic [DATA_WIDTH-1:0] a_reg;
    logic [DATA_WIDTH-1:0] a_next;
    logic [DATA_WIDTH-1:0] b_reg;
    logic [DATA_WIDTH-1:0] b_next;
    logic [DATA_WIDTH-1:0] rn_reg;
    logic [DATA_WIDTH-1:0] rn_next;
    logic [DATA_WIDTH-1:0] res_num_reg;
    logic [DATA_WIDTH-1:0] res_num_next;
    logic [DATA_WIDTH-2:0] res_den_reg;
    logic [DATA_WIDTH-2:0] res_den_next;
    logic                  out_valid_reg;
    logic                  out_valid_next;
    logic [DATA_WIDTH-1:0] out_num_reg;
    logic [DATA_WIDTH-1:0] out_num_next;
    logic [DATA_WIDTH-2:0] out_den_reg;
    logic [DATA_WIDTH-2:0] out_den_next;

    logic                  in_take;
    logic                  n_neg;
    logic                  d_neg;
    logic [DATA_WIDTH-1:0] n_abs;
    logic [DATA_WIDTH-1:0] d_abs;
    logic [DATA_WIDTH-1:0] pos_max;

    logic                  div_start;
    logic [DATA_WIDTH-1:0] div_dividend;
    logic [DATA_WIDTH-1:0] div_divisor;
    rng_div_status_t       div_stat;
    logic [DATA_WIDTH-1:0] div_quot;
    logic [DATA_WIDTH-1:0] div_rem;

    // Magnitudes of the incoming beat; the most negative value maps to 2^(W-1).
    assign n_neg   = numerator_in[DATA_WIDTH-1];
    assign d_neg   = denominator_in[DATA_WIDTH-1];
    assign n_abs   = n_neg ? (~$unsigned(numerator_in) + 1'b1) : $unsigned(numerator_in);
    assign d_abs   = d_neg ? (~$unsigned(denominator_in) + 1'b1) : $unsigned(denominator_in);
    assign pos_max = {1'b0, {(DATA_WIDTH-1){1'b1}}};

    assign in_stall = (state_reg != ST_IDLE);
    assign in_take  = in_valid && !in_stall;

    // Divider launch: Euclid steps divide a by b; the reductions divide by the gcd in a.
    always_comb
    begin
        div_start    = 1'b0;
        div_dividend = a_reg;
        div_divisor  = a_reg;
        case (state_reg)
            ST_GCD_NEXT:
            begin
                div_start    = (b_reg != '0);
                div_dividend = a_reg;
                div_divisor  = b_reg;
            end
            ST_RN_START:
            begin
                div_start    = 1'b1;
                div_dividend = n_mag_reg;
            end
            ST_RD_START:
            begin
                div_start    = 1'b1;
                div_dividend = d_mag_reg;
            end
            default:
            begin
                div_start = 1'b0;
            end
        endcase
    end

    rng_div #(
        .DATA_WIDTH (DATA_WIDTH)
    ) u_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (div_start),
        .dividend  (div_dividend),
        .divisor   (div_divisor),
        .status    (div_stat),
        .quotient  (div_quot),
        .remainder (div_rem)
    );

    // Sequencer next-state and datapath updates.
    always_comb
    begin
        state_next     = state_reg;
        neg_next       = neg_reg;
        n_mag_next     = n_mag_reg;
        d_mag_next     = d_mag_reg;
        a_next         = a_reg;
        b_next         = b_reg;
        rn_next        = rn_reg;
        res_num_next   = res_num_reg;
        res_den_next   = res_den_reg;
        out_valid_next = out_valid_reg;
        out_num_next   = out_num_reg;
        out_den_next   = out_den_reg;

        if (out_valid_reg && !out_stall)
        begin
            out_valid_next = 1'b0;
        end

        case (state_reg)
            ST_IDLE:
            begin
                if (in_take)
                begin
                    neg_next   = n_neg ^ d_neg;
                    n_mag_next = n_abs;
                    d_mag_next = d_abs;
                    a_next     = n_abs;
                    b_next     = d_abs;
                    if (n_abs == '0)
                    begin
                        res_num_next = '0;
                        res_den_next = (DATA_WIDTH-1)'(1);
                        state_next   = ST_FINISH;
                    end
                    else
                    begin
                        state_next = ST_GCD_NEXT;
                    end
                end
            end
            ST_GCD_NEXT:
            begin
                // A zero remainder leaves the gcd in a.
                if (b_reg == '0)
                begin
                    state_next = ST_RN_START;
                end
                else
                begin
                    state_next = ST_GCD_WAIT;
                end
            end
            ST_GCD_WAIT:
            begin
                if (div_stat.done)
                begin
                    a_next     = b_reg;
                    b_next     = div_rem;
                    state_next = ST_GCD_NEXT;
                end
            end
            ST_RN_START:
            begin
                state_next = ST_RN_WAIT;
            end
            ST_RN_WAIT:
            begin
                if (div_stat.done)
                begin
                    rn_next    = div_quot;
                    state_next = ST_RD_START;
                end
            end
            ST_RD_START:
            begin
                state_next = ST_RD_WAIT;
            end
            ST_RD_WAIT:
            begin
                // Apply the sign and saturate what does not fit.
                if (div_stat.done)
                begin
                    if (neg_reg)
                    begin
                        res_num_next = ~rn_reg + 1'b1;
                    end
                    else if (rn_reg[DATA_WIDTH-1])
                    begin
                        res_num_next = pos_max;
                    end
                    else
                    begin
                        res_num_next = rn_reg;
                    end
                    if (div_quot[DATA_WIDTH-1])
                    begin
                        res_den_next = pos_max[DATA_WIDTH-2:0];
                    end
                    else
                    begin
                        res_den_next = div_quot[DATA_WIDTH-2:0];
                    end
                    state_next = ST_FINISH;
                end
            end
            ST_FINISH:
            begin
                // Load the output register once it is empty or being emptied.
                if (!out_valid_reg || !out_stall)
                begin
                    out_valid_next = 1'b1;
                    out_num_next   = res_num_reg;
                    out_den_next   = res_den_reg;
                    state_next     = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // State and registered outputs.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        neg_reg     <= neg_next;
        n_mag_reg   <= n_mag_next;
        d_mag_reg   <= d_mag_next;
        a_reg       <= a_next;
        b_reg       <= b_next;
        rn_reg      <= rn_next;
        res_num_reg <= res_num_next;
        res_den_reg <= res_den_next;
        out_num_reg <= out_num_next;
        out_den_reg <= out_den_next;
    end

    assign out_valid           = out_valid_reg;
    assign reduced_numerator   = $signed(out_num_reg);
    assign reduced_denominator = out_den_reg;

    // The divider is only launched when it is free.
    assert property (@(posedge clk) disable iff (!rst_n)
        div_start |-> !div_stat.busy)
        else $error("divider launched while busy");

    // A divider result only arrives while the sequencer waits for one.
    assert property (@(posedge clk) disable iff (!rst_n)
        div_stat.done |-> (state_reg == ST_GCD_WAIT || state_reg == ST_RN_WAIT ||
                           state_reg == ST_RD_WAIT))
        else $error("divider result outside a wait state");

    // An accepted beat always starts work on the next cycle.
    assert property (@(posedge clk) disable iff (!rst_n)
        in_take |=> (state_reg == ST_GCD_NEXT || state_reg == ST_FINISH))
        else $error("accepted beat did not start the sequencer");

    // A zero result always carries a denominator of one.
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && reduced_numerator == '0) |-> (reduced_denominator == 1))
        else $error("zero numerator without unit denominator");

endmodule

`default_nettype wire

/* tb/sv/tb_rational_normalize_gcd_top.sv */
`default_nettype none

module tb_rational_normalize_gcd_top;

    localparam int W = 32;
    localparam int RANDOM_FRACTIONS = 630;
    localparam int STALL_LIMIT = 20000;
    localparam int DRAIN_CYCLES = 200;
    localparam logic signed [W-1:0] MOST_NEG = {1'b1, {(W-1){1'b0}}};
    localparam logic signed [W-1:0] POS_MAX = {1'b0, {(W-1){1'b1}}};
    localparam logic [W-2:0] DEN_MAX = {(W-1){1'b1}};

    // One row of stimulus; typed rows carry their result, the rest use the predictor.
    typedef struct packed {
        logic signed [W-1:0] num;
        logic signed [W-1:0] den;
        logic                typed;
        logic signed [W-1:0] want_num;
        logic        [W-2:0] want_den;
    } frac_row_t;

    // A fraction in flight together with its reduced form.
    typedef struct packed {
        logic signed [W-1:0] num;
        logic signed [W-1:0] den;
        logic signed [W-1:0] want_num;
        logic        [W-2:0] want_den;
    } reduced_frac_t;

    logic                clk = 1'b0;
    logic                rst_n;
    logic                in_valid;
    logic                in_stall;
    logic signed [W-1:0] numerator_in;
    logic signed [W-1:0] denominator_in;
    logic                out_valid;
    logic                out_stall;
    logic signed [W-1:0] reduced_numerator;
    logic        [W-2:0] reduced_denominator;

    reduced_frac_t reduced_q[$];
    frac_row_t     directed_rows[$];
    int            error_count = 0;
    int            idle_cycles = 0;
    bit            quiet_phase = 1'b0;

    rational_normalize_gcd_top #(
        .DATA_WIDTH(W)
    ) u_top (
        .clk                 (clk),
        .rst_n               (rst_n),
        .in_valid            (in_valid),
        .in_stall            (in_stall),
        .numerator_in        (numerator_in),
        .denominator_in      (denominator_in),
        .out_valid           (out_valid),
        .out_stall           (out_stall),
        .reduced_numerator   (reduced_numerator),
        .reduced_denominator (reduced_denominator)
    );

    // Clock with a period of four time units.
    always
    begin
        clk = 1'b0;
        #2;
        clk = 1'b1;
        #2;
    end

    // Reduces a fraction to lowest terms with the sign moved to the numerator.
    function automatic void reduce_fraction(input logic signed [W-1:0] num,
                                            input logic signed [W-1:0] den,
                                            output logic signed [W-1:0] red_num,
                                            output logic [W-2:0] red_den);
        logic [W-1:0] num_mag;
        logic [W-1:0] den_mag;
        logic [W-1:0] a;
        logic [W-1:0] b;
        logic [W-1:0] rem;
        logic [W-1:0] quo_num;
        logic [W-1:0] quo_den;
        logic         negative;
        num_mag = num[W-1] ? -num : num;
        den_mag = den[W-1] ? -den : den;
        negative = num[W-1] ^ den[W-1];
        if (num_mag == '0)
        begin
            red_num = '0;
            red_den = (W-1)'(1);
            return;
        end
        // Euclid's remainder loop; the numerator magnitude is nonzero here.
        a = num_mag;
        b = den_mag;
        while (b != '0)
        begin
            rem = a % b;
            a = b;
            b = rem;
        end
        quo_num = num_mag / a;
        quo_den = den_mag / a;
        if (negative)
            red_num = -quo_num;
        else
            red_num = (quo_num > POS_MAX) ? POS_MAX : quo_num;
        red_den = (quo_den > {1'b0, DEN_MAX}) ? DEN_MAX : quo_den[W-2:0];
    endfunction

    function automatic frac_row_t row(input logic signed [W-1:0] num,
                                      input logic signed [W-1:0] den,
                                      input logic typed,
                                      input logic signed [W-1:0] want_num,
                                      input logic [W-2:0] want_den);
        row = '{num, den, typed, want_num, want_den};
    endfunction

    function automatic logic signed [W-1:0] with_random_sign(input longint unsigned mag);
        logic [W-1:0] v;
        v = mag[W-1:0];
        return ($urandom_range(0, 1) != 0) ? -v : v;
    endfunction

    // Wait before the next beat: none during quiet phases.
    function automatic int draw_idle();
        return quiet_phase ? 0 : $urandom_range(0, 9);
    endfunction

    // Random fraction, weighted toward shared factors and long Euclid chains.
    function automatic void draw_fraction(output logic signed [W-1:0] num,
                                          output logic signed [W-1:0] den);
        int unsigned    pick;
        int unsigned    lim;
        longint unsigned a;
        longint unsigned b;
        longint unsigned g;
        longint unsigned f0;
        longint unsigned f1;
        longint unsigned f2;
        int             steps;
        pick = $urandom_range(0, 99);
        if (pick < 35)
        begin
            a = 64'($urandom_range(1, 2000));
            b = 64'($urandom_range(1, 2000));
            lim = 32'(32'h7fff_ffff / ((a > b) ? a : b));
            g = 64'($urandom_range(1, lim));
            num = with_random_sign(a * g);
            den = with_random_sign(b * g);
        end
        else if (pick < 55)
        begin
            num = $urandom;
            den = $urandom;
        end
        else if (pick < 65)
        begin
            case ($urandom_range(0, 3))
                0: begin num = '0; den = '0; end
                1: begin num = $urandom; den = '0; end
                default: begin num = '0; den = $urandom; end
            endcase
        end
        else if (pick < 80)
        begin
            num = $urandom_range(0, 200) - 100;
            den = $urandom_range(0, 200) - 100;
        end
        else if (pick < 90)
        begin
            a = (64'd1 << $urandom_range(0, 30)) + $urandom_range(0, 2) - 1;
            b = (64'd1 << $urandom_range(0, 30)) + $urandom_range(0, 2) - 1;
            num = with_random_sign(a);
            den = with_random_sign(b);
        end
        else
        begin
            // Consecutive Fibonacci numbers give the longest remainder chains.
            f0 = 1;
            f1 = 1;
            steps = $urandom_range(1, 44);
            for (int i = 0; i < steps; i++)
            begin
                f2 = f0 + f1;
                f0 = f1;
                f1 = f2;
            end
            if ($urandom_range(0, 1) != 0)
            begin
                num = with_random_sign(f1);
                den = with_random_sign(f0);
            end
            else
            begin
                num = with_random_sign(f0);
                den = with_random_sign(f1);
            end
        end
    endfunction

    // Drives one fraction beat and records its reduced form once accepted.
    task automatic send_fraction(input frac_row_t r);
        int            gap;
        reduced_frac_t exp_item;
        gap = draw_idle();
        if (gap != 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid       <= 1'b1;
        numerator_in   <= r.num;
        denominator_in <= r.den;
        do @(posedge clk); while (in_stall);
        exp_item.num = r.num;
        exp_item.den = r.den;
        if (r.typed)
        begin
            exp_item.want_num = r.want_num;
            exp_item.want_den = r.want_den;
        end
        else
            reduce_fraction(r.num, r.den, exp_item.want_num, exp_item.want_den);
        reduced_q.push_back(exp_item);
    endtask

    // Result side: at random, stall until a beat is offered and for a random wait after it.
    initial
    begin
        int gap;
        out_stall <= 1'b0;
        forever
        begin
            gap = draw_idle();
            if (gap != 0)
            begin
                out_stall <= 1'b1;
                do @(posedge clk); while (!out_valid);
                repeat (gap - 1) @(posedge clk);
                out_stall <= 1'b0;
            end
            do @(posedge clk); while (!(out_valid && !out_stall));
        end
    end

    // Compare every accepted result with the oldest pending fraction.
    always @(posedge clk)
    begin
        reduced_frac_t exp_item;
        if (rst_n === 1'b1 && out_valid && !out_stall)
        begin
            if (reduced_q.size() == 0)
            begin
                $display("%0t unexpected result %0d/%0d", $time,
                         reduced_numerator, reduced_denominator);
                error_count++;
            end
            else
            begin
                exp_item = reduced_q.pop_front();
                if (reduced_numerator !== exp_item.want_num)
                begin
                    $display("%0t reduced_numerator for %0d/%0d: expected %0d, got %0d",
                             $time, exp_item.num, exp_item.den, exp_item.want_num,
                             reduced_numerator);
                    error_count++;
                end
                if (reduced_denominator !== exp_item.want_den)
                begin
                    $display("%0t reduced_denominator for %0d/%0d: expected %0d, got %0d",
                             $time, exp_item.num, exp_item.den, exp_item.want_den,
                             reduced_denominator);
                    error_count++;
                end
            end
        end
    end

    // Watchdog: too long without any beat on either side ends the run.
    always @(posedge clk)
    begin
        if ((in_valid && in_stall === 1'b0) || (out_valid === 1'b1 && !out_stall))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= STALL_LIMIT)
        begin
            $display("simulation failed");
            $finish;
        end
    end

    // Stimulus: directed fractions first, then random ones.
    initial
    begin
        logic signed [W-1:0] num;
        logic signed [W-1:0] den;
        int                  count;
        rst_n          <= 1'b0;
        in_valid       <= 1'b0;
        numerator_in   <= '0;
        denominator_in <= '0;

        // Zeros, zero denominators, extremes, most negative inputs, signs, long chains.
        directed_rows.push_back(row(0, 0, 1'b1, 0, 1));
        directed_rows.push_back(row(0, -5, 1'b1, 0, 1));
        directed_rows.push_back(row(0, MOST_NEG, 1'b1, 0, 1));
        directed_rows.push_back(row(5, 0, 1'b1, 1, 0));
        directed_rows.push_back(row(-7, 0, 1'b1, -1, 0));
        directed_rows.push_back(row(MOST_NEG, 0, 1'b1, -1, 0));
        directed_rows.push_back(row(POS_MAX, POS_MAX, 1'b1, 1, 1));
        directed_rows.push_back(row(-POS_MAX, POS_MAX, 1'b1, -1, 1));
        directed_rows.push_back(row(POS_MAX, -POS_MAX, 1'b1, -1, 1));
        directed_rows.push_back(row(-POS_MAX, -POS_MAX, 1'b1, 1, 1));
        directed_rows.push_back(row(-1, -1, 1'b1, 1, 1));
        directed_rows.push_back(row(POS_MAX, 1, 1'b1, POS_MAX, 1));
        directed_rows.push_back(row(1, POS_MAX, 1'b1, 1, DEN_MAX));
        directed_rows.push_back(row(MOST_NEG, -1, 1'b1, POS_MAX, 1));
        directed_rows.push_back(row(MOST_NEG, 1, 1'b1, MOST_NEG, 1));
        directed_rows.push_back(row(1, MOST_NEG, 1'b1, -1, DEN_MAX));
        directed_rows.push_back(row(3, MOST_NEG, 1'b1, -3, DEN_MAX));
        directed_rows.push_back(row(MOST_NEG, MOST_NEG, 1'b1, 1, 1));
        directed_rows.push_back(row(MOST_NEG, 2, 1'b0, 0, 0));
        directed_rows.push_back(row(6, 4, 1'b1, 3, 2));
        directed_rows.push_back(row(-6, 4, 1'b1, -3, 2));
        directed_rows.push_back(row(6, -4, 1'b1, -3, 2));
        directed_rows.push_back(row(1836311903, 1134903170, 1'b0, 0, 0));
        directed_rows.push_back(row(-1134903170, 1836311903, 1'b0, 0, 0));
        directed_rows.push_back(row(1 << 30, 1 << 20, 1'b0, 0, 0));

        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        count = 0;
        foreach (directed_rows[i])
        begin
            send_fraction(directed_rows[i]);
            count++;
        end

        // Alternate phases with and without idle cycles every forty beats.
        for (int i = 0; i < RANDOM_FRACTIONS; i++)
        begin
            quiet_phase = ((count / 40) % 2) == 1;
            draw_fraction(num, den);
            send_fraction(row(num, den, 1'b0, 0, 0));
            count++;
        end
        in_valid <= 1'b0;
        quiet_phase = 1'b0;

        // Drain outstanding results, then watch for strays.
        while (reduced_q.size() != 0) @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (error_count == 0 && reduced_q.size() == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule

`default_nettype wire

/* sim.f */
sv/rng_pkg.sv
sv/rng_div.sv
sv/rational_normalize_gcd_top.sv
tb/sv/tb_rational_normalize_gcd_top.sv
